// File: rtl/core/imuacf_pkg.sv
package imuacf_pkg;

    // sample and angle formats
    localparam int SAMPLE_BITS      = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int STEP_W           = 5;    // iteration index for the CORDIC steps
    localparam int CW               = 54;   // CORDIC x/y datapath
    localparam int ZW               = 27;   // CORDIC angle, 1/65536 degree
    localparam int FW               = 24;   // filter and fused state
    localparam int AW               = 16;   // output angle, 1/128 degree
    localparam int IN_W             = 9 * SAMPLE_BITS;
    localparam int OUT_W            = 6 * AW;
    localparam int QDEPTH           = 2;

    // configuration port
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 16;

    localparam logic [CFG_AW-1:0] REG_MAG_OFFSET_X    = 3'd0;
    localparam logic [CFG_AW-1:0] REG_MAG_OFFSET_Y    = 3'd1;
    localparam logic [CFG_AW-1:0] REG_MAG_OFFSET_Z    = 3'd2;
    localparam logic [CFG_AW-1:0] REG_GYRO_SMOOTHING  = 3'd3;
    localparam logic [CFG_AW-1:0] REG_ACCEL_SMOOTHING = 3'd4;
    localparam logic [CFG_AW-1:0] REG_BLEND_WEIGHT    = 3'd5;
    localparam logic [CFG_AW-1:0] REG_GYRO_STEP_GAIN  = 3'd6;
    localparam logic [CFG_AW-1:0] REG_DECLINATION     = 3'd7;

    // angle constants
    localparam logic signed [ZW-1:0] DEG180      = 27'sd11796480;
    localparam logic signed [ZW-1:0] DEG90       = 27'sd5898240;
    localparam logic signed [AW-1:0] ANG_LIMIT   = 16'sd23040;
    localparam logic signed [FW-1:0] FUSED_LIMIT = 24'sd5898240;
    localparam logic signed [CW-1:0] ROT_X0      = 54'sd652032875;
    localparam logic [8:0]           WEIGHT_MAX  = 9'd256;

    typedef struct packed {
        logic signed [15:0] mag_offset_x;
        logic signed [15:0] mag_offset_y;
        logic signed [15:0] mag_offset_z;
        logic [8:0]         gyro_smoothing;
        logic [8:0]         accel_smoothing;
        logic [8:0]         blend_weight;
        logic [15:0]        gyro_step_gain;
        logic signed [15:0] declination;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        mag_offset_x:    16'sd1446,
        mag_offset_y:    16'sd352,
        mag_offset_z:    16'sd704,
        gyro_smoothing:  9'd26,
        accel_smoothing: 9'd154,
        blend_weight:    9'd77,
        gyro_step_gain:  16'd367,
        declination:     16'sd584
    };

    // first member is the top bits: accel_x lands in the lowest bits
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] field_z;
        logic signed [SAMPLE_BITS-1:0] field_y;
        logic signed [SAMPLE_BITS-1:0] field_x;
        logic signed [SAMPLE_BITS-1:0] rate_z;
        logic signed [SAMPLE_BITS-1:0] rate_y;
        logic signed [SAMPLE_BITS-1:0] rate_x;
        logic signed [SAMPLE_BITS-1:0] accel_z;
        logic signed [SAMPLE_BITS-1:0] accel_y;
        logic signed [SAMPLE_BITS-1:0] accel_x;
    } item_t;

    typedef struct packed {
        logic                 start;
        logic                 rot;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_req_t;

    typedef struct packed {
        logic                 done;
        logic signed [ZW-1:0] ang;
        logic signed [CW-1:0] mag;
        logic signed [17:0]   cosv;
        logic signed [17:0]   sinv;
    } cordic_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MAT_X,
        ST_MAT_Y,
        ST_MAT_Z,
        ST_LPF,
        ST_ROLL_GO,
        ST_ROLL_WAIT,
        ST_MAGC,
        ST_PITCH_GO,
        ST_PITCH_WAIT,
        ST_PRED,
        ST_BLEND,
        ST_ROTR_GO,
        ST_ROTR_WAIT,
        ST_ROTP_GO,
        ST_ROTP_WAIT,
        ST_H1,
        ST_H2,
        ST_H3,
        ST_H4,
        ST_H5,
        ST_H6,
        ST_H7,
        ST_HEAD_GO,
        ST_HEAD_WAIT,
        ST_HEAD_FIX,
        ST_OUT
    } seq_st_t;

    // arctangent of 2^-i in 1/65536 degree, rounded
    function automatic logic signed [ZW-1:0] atan_entry(input logic [STEP_W-1:0] i);
        logic signed [ZW-1:0] r;
        case (i)
            5'd0:    r = 27'sd2949120;
            5'd1:    r = 27'sd1740967;
            5'd2:    r = 27'sd919879;
            5'd3:    r = 27'sd466945;
            5'd4:    r = 27'sd234379;
            5'd5:    r = 27'sd117304;
            5'd6:    r = 27'sd58666;
            5'd7:    r = 27'sd29335;
            5'd8:    r = 27'sd14668;
            5'd9:    r = 27'sd7334;
            5'd10:   r = 27'sd3667;
            5'd11:   r = 27'sd1833;
            5'd12:   r = 27'sd917;
            5'd13:   r = 27'sd458;
            5'd14:   r = 27'sd229;
            5'd15:   r = 27'sd115;
            5'd16:   r = 27'sd57;
            5'd17:   r = 27'sd29;
            5'd18:   r = 27'sd14;
            5'd19:   r = 27'sd7;
            5'd20:   r = 27'sd4;
            5'd21:   r = 27'sd2;
            5'd22:   r = 27'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/imuacf_front.sv
module imuacf_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [imuacf_pkg::IN_W-1:0] s_tdata,
    output logic                        item_valid,
    output imuacf_pkg::item_t           item,
    input  logic                        item_pop
);
    import imuacf_pkg::*;

    item_t q_reg [QDEPTH];
    item_t in_item;
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic       push, pop;

    // split the bus word into sensor fields
    assign in_item    = s_tdata;
    assign s_tready   = (cnt_reg != 2'(QDEPTH));
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = q_reg[rp_reg];
    assign push       = s_tvalid && s_tready;
    assign pop        = item_pop && item_valid;

    // queue pointers and fill count
    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wp_reg] <= in_item;
        end
    end

endmodule

// File: rtl/core/imuacf_cordic.sv
module imuacf_cordic #(
    parameter int CORDIC_STEPS = imuacf_pkg::CORDIC_STEPS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  imuacf_pkg::cordic_req_t req,
    output imuacf_pkg::cordic_rsp_t rsp
);
    import imuacf_pkg::*;

    localparam logic [STEP_W-1:0]    LAST  = STEP_W'(CORDIC_STEPS - 1);
    localparam logic signed [CW-1:0] RND15 = CW'(16384);

    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic [STEP_W-1:0]    i_reg, i_next;
    logic                 run_reg, run_next, done_reg, done_next;
    logic                 rot_reg, rot_next, neg_reg, neg_next, zero_reg, zero_next;
    logic signed [CW-1:0] xs, ys, xr, yr;
    logic signed [ZW-1:0] at;

    // one micro-rotation per cycle
    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        i_next    = i_reg;
        run_next  = run_reg;
        rot_next  = rot_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        done_next = 1'b0;
        xs        = x_reg >>> i_reg;
        ys        = y_reg >>> i_reg;
        at        = atan_entry(i_reg);
        if (req.start) begin
            i_next    = '0;
            run_next  = 1'b1;
            rot_next  = req.rot;
            neg_next  = 1'b0;
            zero_next = 1'b0;
            x_next    = req.x;
            y_next    = req.y;
            z_next    = req.z;
            if (req.rot) begin
                // fold into +-90 degrees, flip result sign
                if (req.z > DEG90) begin
                    z_next   = req.z - DEG180;
                    neg_next = 1'b1;
                end else if (req.z < -DEG90) begin
                    z_next   = req.z + DEG180;
                    neg_next = 1'b1;
                end
            end else begin
                z_next    = '0;
                zero_next = (req.x == '0) && (req.y == '0);
                if (req.x < 0) begin
                    x_next = -req.x;
                    y_next = -req.y;
                    z_next = (req.y >= 0) ? DEG180 : -DEG180;
                end
            end
        end else if (run_reg) begin
            if (rot_reg) begin
                if (!z_reg[ZW-1]) begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - at;
                end else begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + at;
                end
            end else begin
                if (y_reg > 0) begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + at;
                end else begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - at;
                end
            end
            i_next = i_reg + 1'b1;
            if (i_reg == LAST) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        i_reg    <= i_next;
        rot_reg  <= rot_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
    end

    // result shaping: Q30 to Q15, angle clamp, zero vector
    always_comb begin
        xr       = (x_reg + RND15) >>> 15;
        yr       = (y_reg + RND15) >>> 15;
        rsp.done = done_reg;
        rsp.cosv = neg_reg ? -xr[17:0] : xr[17:0];
        rsp.sinv = neg_reg ? -yr[17:0] : yr[17:0];
        rsp.mag  = zero_reg ? '0 : x_reg;
        if (zero_reg) begin
            rsp.ang = '0;
        end else if (z_reg > DEG180) begin
            rsp.ang = DEG180;
        end else if (z_reg < -DEG180) begin
            rsp.ang = -DEG180;
        end else begin
            rsp.ang = z_reg;
        end
    end

endmodule

// File: rtl/core/imuacf_back.sv
module imuacf_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  imuacf_pkg::cfg_t             cfg,
    input  logic                         item_valid,
    input  imuacf_pkg::item_t            item,
    output logic                         item_pop,
    output imuacf_pkg::cordic_req_t      creq,
    input  imuacf_pkg::cordic_rsp_t      crsp,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [imuacf_pkg::OUT_W-1:0] m_tdata
);
    import imuacf_pkg::*;

    // round 1/65536 degree to 1/128 degree and clamp
    function automatic logic signed [AW-1:0] to_q128(input logic signed [ZW-1:0] z);
        logic signed [ZW:0]   t;
        logic signed [ZW-9:0] q;
        t = (ZW+1)'(z) + (ZW+1)'(256);
        q = t[ZW:9];
        if (q > ANG_LIMIT) begin
            q = (ZW-8)'(ANG_LIMIT);
        end else if (q < -ANG_LIMIT) begin
            q = -(ZW-8)'(ANG_LIMIT);
        end
        return q[AW-1:0];
    endfunction

    function automatic logic [8:0] wsat(input logic [8:0] w);
        return (w > WEIGHT_MAX) ? WEIGHT_MAX : w;
    endfunction

    // first-order low-pass, w in 1/256
    function automatic logic signed [FW-1:0] lowpass(input logic signed [FW-1:0] old,
                                                     input logic signed [15:0] smp,
                                                     input logic [8:0] w);
        logic signed [9:0]    ws;
        logic signed [9:0]    wc;
        logic signed [FW+10:0] acc;
        ws  = $signed({1'b0, w});
        wc  = 10'sd256 - ws;
        acc = (FW+11)'(old) * (FW+11)'(wc) + (((FW+11)'(smp) * (FW+11)'(ws)) <<< 8);
        return acc[FW+7:8];
    endfunction

    // one row of the soft-iron matrix, Q14, rounded
    function automatic logic signed [17:0] mat_row(input logic signed [16:0] a,
                                                   input logic signed [16:0] b,
                                                   input logic signed [16:0] c,
                                                   input int ka, input int kb, input int kc);
        logic signed [33:0] acc;
        acc = 34'(a) * 34'(ka) + 34'(b) * 34'(kb) + 34'(c) * 34'(kc) + 34'sd8192;
        return acc[31:14];
    endfunction

    function automatic logic signed [AW-1:0] fused_out(input logic signed [FW-1:0] f);
        logic signed [FW:0]   t;
        logic signed [FW-8:0] q;
        t = (FW+1)'(f) + (FW+1)'(128);
        q = t[FW:8];
        if (q > ANG_LIMIT) begin
            q = (FW-7)'(ANG_LIMIT);
        end else if (q < -ANG_LIMIT) begin
            q = -(FW-7)'(ANG_LIMIT);
        end
        return q[AW-1:0];
    endfunction

    seq_st_t st_reg, st_next;
    logic [2:0] k_reg, k_next;
    logic [1:0] f_reg, f_next;
    logic signed [15:0]   samp_reg [6];
    logic signed [15:0]   samp_next [6];
    logic signed [FW-1:0] filt_reg [6];
    logic signed [FW-1:0] filt_next [6];
    logic signed [FW-1:0] prev_reg [3];
    logic signed [FW-1:0] prev_next [3];
    logic signed [16:0]   m_reg [3];
    logic signed [16:0]   m_next [3];
    logic signed [17:0]   cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    logic signed [17:0]   cr_reg, cr_next, sr_reg, sr_next, cp_reg, cp_next, sp_reg, sp_next;
    logic signed [AW-1:0] roll_reg, roll_next, pitch_reg, pitch_next, head_reg, head_next;
    logic signed [25:0]   pred_reg, pred_next;
    logic signed [26:0]   magc_reg, magc_next;
    logic signed [35:0]   t1_reg, t1_next, t2_reg, t2_next;
    logic signed [CW-1:0] num_reg, num_next, den_reg, den_next;
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]     out_data_reg, out_data_next;

    logic [8:0]           w_cur;
    logic signed [FW-1:0] rate_sel, prev_sel;
    logic signed [AW-1:0] meas_sel;
    logic signed [40:0]   step_prod;
    logic signed [9:0]    bs, bc;
    logic signed [36:0]   blend_acc;
    logic signed [28:0]   blend_q;
    logic signed [FW-1:0] blend_sat;
    logic signed [45:0]   magc_prod;
    logic signed [36:0]   num_diff;
    logic signed [17:0]   head_wrap;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // per-axis and per-angle operand selection
    always_comb begin
        w_cur = (k_reg < 3'd3) ? wsat(cfg.accel_smoothing) : wsat(cfg.gyro_smoothing);
        case (f_reg)
            2'd0: begin
                rate_sel = filt_reg[3];
                prev_sel = prev_reg[0];
                meas_sel = roll_reg;
            end
            2'd1: begin
                rate_sel = filt_reg[4];
                prev_sel = prev_reg[1];
                meas_sel = pitch_reg;
            end
            default: begin
                rate_sel = filt_reg[5];
                prev_sel = prev_reg[2];
                meas_sel = head_reg;
            end
        endcase
        step_prod = 41'(rate_sel) * 41'($signed({1'b0, cfg.gyro_step_gain}));
        bs        = $signed({1'b0, wsat(cfg.blend_weight)});
        bc        = 10'sd256 - bs;
        blend_acc = 37'(pred_reg) * 37'(bc) + ((37'(meas_sel) * 37'(bs)) <<< 8);
        blend_q   = blend_acc[36:8];
        if (blend_q > FUSED_LIMIT) begin
            blend_sat = FUSED_LIMIT;
        end else if (blend_q < -FUSED_LIMIT) begin
            blend_sat = -FUSED_LIMIT;
        end else begin
            blend_sat = blend_q[FW-1:0];
        end
        magc_prod = 46'($signed(crsp.mag[27:0])) * 46'sd39797 + 46'sd32768;
        num_diff  = 37'(cz_reg) * 37'(sr_reg) - 37'(t1_reg);
        head_wrap = 18'(to_q128(crsp.ang)) - 18'(cfg.declination);
        if (head_wrap > 18'sd23040) begin
            head_wrap = head_wrap - 18'sd46080;
        end else if (head_wrap < -18'sd23040) begin
            head_wrap = head_wrap + 18'sd46080;
        end
        if (head_wrap > 18'sd23040) begin
            head_wrap = 18'sd23040;
        end else if (head_wrap < -18'sd23040) begin
            head_wrap = -18'sd23040;
        end
    end

    // sequencer: next state and datapath updates
    always_comb begin
        st_next        = st_reg;
        k_next         = k_reg;
        f_next         = f_reg;
        samp_next      = samp_reg;
        filt_next      = filt_reg;
        prev_next      = prev_reg;
        m_next         = m_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cz_next        = cz_reg;
        cr_next        = cr_reg;
        sr_next        = sr_reg;
        cp_next        = cp_reg;
        sp_next        = sp_reg;
        roll_next      = roll_reg;
        pitch_next     = pitch_reg;
        head_next      = head_reg;
        pred_next      = pred_reg;
        magc_next      = magc_reg;
        t1_next        = t1_reg;
        t2_next        = t2_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        item_pop       = 1'b0;
        creq           = '0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (st_reg)
            ST_IDLE: begin
                if (item_valid) begin
                    item_pop     = 1'b1;
                    samp_next[0] = item.accel_x;
                    samp_next[1] = item.accel_y;
                    samp_next[2] = item.accel_z;
                    samp_next[3] = item.rate_x;
                    samp_next[4] = item.rate_y;
                    samp_next[5] = item.rate_z;
                    m_next[0]    = 17'(item.field_x) - 17'(cfg.mag_offset_x);
                    m_next[1]    = 17'(item.field_y) - 17'(cfg.mag_offset_y);
                    m_next[2]    = 17'(item.field_z) - 17'(cfg.mag_offset_z);
                    st_next      = ST_MAT_X;
                end
            end
            ST_MAT_X: begin
                cx_next = mat_row(m_reg[0], m_reg[1], m_reg[2], 16384, 542, -141);
                st_next = ST_MAT_Y;
            end
            ST_MAT_Y: begin
                cy_next = mat_row(m_reg[0], m_reg[1], m_reg[2], 542, 16061, 365);
                st_next = ST_MAT_Z;
            end
            ST_MAT_Z: begin
                cz_next = mat_row(m_reg[0], m_reg[1], m_reg[2], -141, 365, 16590);
                k_next  = '0;
                st_next = ST_LPF;
            end
            ST_LPF: begin
                // rotate the six axes through one filter slot
                for (int i = 0; i < 5; i++) begin
                    filt_next[i] = filt_reg[i+1];
                    samp_next[i] = samp_reg[i+1];
                end
                filt_next[5] = lowpass(filt_reg[0], samp_reg[0], w_cur);
                samp_next[5] = samp_reg[0];
                k_next       = k_reg + 1'b1;
                if (k_reg == 3'd5) begin
                    st_next = ST_ROLL_GO;
                end
            end
            ST_ROLL_GO: begin
                creq.start = 1'b1;
                creq.x     = CW'(filt_reg[2]);
                creq.y     = CW'(filt_reg[1]);
                st_next    = ST_ROLL_WAIT;
            end
            ST_ROLL_WAIT: begin
                if (crsp.done) begin
                    roll_next = to_q128(crsp.ang);
                    st_next   = ST_MAGC;
                end
            end
            ST_MAGC: begin
                magc_next = magc_prod[42:16];
                st_next   = ST_PITCH_GO;
            end
            ST_PITCH_GO: begin
                creq.start = 1'b1;
                creq.x     = CW'(magc_reg);
                creq.y     = -CW'(filt_reg[0]);
                st_next    = ST_PITCH_WAIT;
            end
            ST_PITCH_WAIT: begin
                if (crsp.done) begin
                    pitch_next = to_q128(crsp.ang);
                    f_next     = 2'd0;
                    st_next    = ST_PRED;
                end
            end
            ST_PRED: begin
                pred_next = 26'(prev_sel) + 26'($signed(step_prod[40:16]));
                st_next   = ST_BLEND;
            end
            ST_BLEND: begin
                case (f_reg)
                    2'd0: begin
                        prev_next[0] = blend_sat;
                        f_next       = 2'd1;
                        st_next      = ST_PRED;
                    end
                    2'd1: begin
                        prev_next[1] = blend_sat;
                        st_next      = ST_ROTR_GO;
                    end
                    default: begin
                        prev_next[2] = blend_sat;
                        st_next      = ST_OUT;
                    end
                endcase
            end
            ST_ROTR_GO: begin
                creq.start = 1'b1;
                creq.rot   = 1'b1;
                creq.x     = ROT_X0;
                creq.z     = ZW'(prev_reg[0]) <<< 1;
                st_next    = ST_ROTR_WAIT;
            end
            ST_ROTR_WAIT: begin
                if (crsp.done) begin
                    cr_next = crsp.cosv;
                    sr_next = crsp.sinv;
                    st_next = ST_ROTP_GO;
                end
            end
            ST_ROTP_GO: begin
                creq.start = 1'b1;
                creq.rot   = 1'b1;
                creq.x     = ROT_X0;
                creq.z     = ZW'(prev_reg[1]) <<< 1;
                st_next    = ST_ROTP_WAIT;
            end
            ST_ROTP_WAIT: begin
                if (crsp.done) begin
                    cp_next = crsp.cosv;
                    sp_next = crsp.sinv;
                    st_next = ST_H1;
                end
            end
            // tilt compensation, one product per cycle
            ST_H1: begin
                t1_next = 36'(cy_reg) * 36'(cr_reg);
                st_next = ST_H2;
            end
            ST_H2: begin
                num_next = CW'(num_diff) <<< 15;
                st_next  = ST_H3;
            end
            ST_H3: begin
                t1_next = 36'(cx_reg) * 36'(cp_reg);
                st_next = ST_H4;
            end
            ST_H4: begin
                t2_next = 36'(cy_reg) * 36'(sp_reg);
                st_next = ST_H5;
            end
            ST_H5: begin
                den_next = CW'(t2_reg) * CW'(sr_reg) - (CW'(t1_reg) <<< 15);
                st_next  = ST_H6;
            end
            ST_H6: begin
                t1_next = 36'(cz_reg) * 36'(sp_reg);
                st_next = ST_H7;
            end
            ST_H7: begin
                den_next = den_reg + CW'(t1_reg) * CW'(cr_reg);
                st_next  = ST_HEAD_GO;
            end
            ST_HEAD_GO: begin
                creq.start = 1'b1;
                creq.x     = den_reg;
                creq.y     = num_reg;
                st_next    = ST_HEAD_WAIT;
            end
            ST_HEAD_WAIT: begin
                if (crsp.done) begin
                    st_next = ST_HEAD_FIX;
                end
            end
            ST_HEAD_FIX: begin
                // declination, wrap into +-180 degrees
                head_next = head_wrap[AW-1:0];
                f_next    = 2'd2;
                st_next   = ST_PRED;
            end
            ST_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    out_data_next  = {-fused_out(prev_reg[2]), fused_out(prev_reg[1]),
                                      fused_out(prev_reg[0]), -head_reg, -pitch_reg,
                                      roll_reg};
                    out_valid_next = 1'b1;
                    st_next        = ST_IDLE;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    // control and filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                filt_reg[i] <= '0;
            end
            for (int i = 0; i < 3; i++) begin
                prev_reg[i] <= '0;
            end
        end else begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
            filt_reg      <= filt_next;
            prev_reg      <= prev_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        k_reg        <= k_next;
        f_reg        <= f_next;
        samp_reg     <= samp_next;
        m_reg        <= m_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        cz_reg       <= cz_next;
        cr_reg       <= cr_next;
        sr_reg       <= sr_next;
        cp_reg       <= cp_next;
        sp_reg       <= sp_next;
        roll_reg     <= roll_next;
        pitch_reg    <= pitch_next;
        head_reg     <= head_next;
        pred_reg     <= pred_next;
        magc_reg     <= magc_next;
        t1_reg       <= t1_next;
        t2_reg       <= t2_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        out_data_reg <= out_data_next;
    end

endmodule

// File: rtl/core/imu_attitude_complementary_filter_unit.sv
// Channel  | Direction | Handshake          | Payload
// s_       | in        | s_tvalid/s_tready  | s_tdata: nine raw sensor samples, 16 bits each
// m_       | out       | m_tvalid/m_tready  | m_tdata: measured and fused angles, 16 bits each
// cfg_     | in        | cfg_we             | cfg_addr selects register, cfg_wdata value
//
// Each item makes five passes through the single shared CORDIC unit,
// one micro-rotation per cycle.
// A two-item input queue accepts while the sequencer works or a result waits, until full.
// Reset (aresetn low, synchronous) clears filter and fused state and loads
// register defaults. Output stalls hold the sequencer at its final step.
module imu_attitude_complementary_filter_unit #(
    parameter int CORDIC_STEPS = imuacf_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, field_x, field_y, field_z
    input  logic [imuacf_pkg::IN_W-1:0]   s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // roll_measured, pitch_measured, heading_measured, roll_fused, pitch_fused,
    // heading_fused
    output logic [imuacf_pkg::OUT_W-1:0]  m_tdata,
    input  logic                          cfg_we,
    input  logic [imuacf_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [imuacf_pkg::CFG_DW-1:0] cfg_wdata
);
    import imuacf_pkg::*;

    cfg_t        cfg_reg, cfg_next;
    item_t       item;
    logic        item_valid, item_pop;
    cordic_req_t creq;
    cordic_rsp_t crsp;

    // register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                REG_MAG_OFFSET_X:    cfg_next.mag_offset_x    = $signed(cfg_wdata);
                REG_MAG_OFFSET_Y:    cfg_next.mag_offset_y    = $signed(cfg_wdata);
                REG_MAG_OFFSET_Z:    cfg_next.mag_offset_z    = $signed(cfg_wdata);
                REG_GYRO_SMOOTHING:  cfg_next.gyro_smoothing  = cfg_wdata[8:0];
                REG_ACCEL_SMOOTHING: cfg_next.accel_smoothing = cfg_wdata[8:0];
                REG_BLEND_WEIGHT:    cfg_next.blend_weight    = cfg_wdata[8:0];
                REG_GYRO_STEP_GAIN:  cfg_next.gyro_step_gain  = cfg_wdata;
                REG_DECLINATION:     cfg_next.declination     = $signed(cfg_wdata);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    imuacf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    imuacf_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (creq),
        .rsp     (crsp)
    );

    imuacf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .creq       (creq),
        .crsp       (crsp),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
